// ----- src/assert_macros.svh -----
// Assertion macros used by the checker file of this project.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");

`endif

// ----- src/hrhp_pkg.sv -----
// Shared types and constants of the HTTP response head parser.
// No dependencies.
package hrhp_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [2:0] ROLE_FRAME  = 3'd0;
  localparam logic [2:0] ROLE_VER    = 3'd1;
  localparam logic [2:0] ROLE_NAME   = 3'd2;
  localparam logic [2:0] ROLE_VALUE  = 3'd3;
  localparam logic [2:0] ROLE_BODY   = 3'd4;

  localparam logic [1:0] RES_BUSY = 2'd0;
  localparam logic [1:0] RES_DONE = 2'd1;
  localparam logic [1:0] RES_BAD  = 2'd2;

  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  // Character classes worked out by the front end.
  typedef struct packed {
    logic digit;
    logic token;
    logic ctl;
    logic lws;
  } cls_t;

  typedef struct packed {
    logic       start;
    logic [7:0] data;
    cls_t       cls;
  } qent_t;

endpackage

// ----- src/hrhp_front.sv -----
// Front end: accepts input bytes and tags each with its character class.
// Depends on hrhp_pkg.
module hrhp_front (
  input  logic              in_start_req,
  input  logic [7:0]        in_data_byte,
  output hrhp_pkg::qent_t   ent
);

  function automatic logic is_sep(input logic [7:0] c);
    logic r;
    begin
      case (c)
        8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h3A, 8'h5C, 8'h22,
        8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B, 8'h7D, 8'h20, 8'h09: r = 1'b1;
        default: r = 1'b0;
      endcase
      return r;
    end
  endfunction

  logic ascii;
  logic ctl;

  assign ascii = !in_data_byte[7];
  assign ctl   = (in_data_byte <= 8'd31) || (in_data_byte == 8'd127);

  always_comb begin
    ent.start     = in_start_req;
    ent.data      = in_data_byte;
    ent.cls.digit = (in_data_byte >= 8'h30) && (in_data_byte <= 8'h39);
    ent.cls.ctl   = ctl;
    ent.cls.token = ascii && !ctl && !is_sep(in_data_byte);
    ent.cls.lws   = (in_data_byte == hrhp_pkg::CH_SP) || (in_data_byte == hrhp_pkg::CH_TAB);
  end

endmodule

// ----- src/hrhp_fifo.sv -----
// Short queue between the classifier and the parsing state machine.
// Depends on hrhp_pkg.
module hrhp_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  hrhp_pkg::qent_t wr_data,
  output logic            full,
  input  logic            rd_en,
  output logic            not_empty,
  output hrhp_pkg::qent_t rd_data
);

  hrhp_pkg::qent_t mem [hrhp_pkg::QDEPTH];

  logic [hrhp_pkg::QAW-1:0] wptr_r, rptr_r;
  logic [hrhp_pkg::QAW:0]   cnt_r, cnt_nxt;

  assign full      = (cnt_r == (hrhp_pkg::QAW+1)'(hrhp_pkg::QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign rd_data   = mem[rptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr_en && !rd_en) cnt_nxt = cnt_r + 1'b1;
    else if (rd_en && !wr_en) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wptr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (wr_en) wptr_r <= wptr_r + 1'b1;
      if (rd_en) rptr_r <= rptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- src/hrhp_back.sv -----
// Back end: the parsing state machine and the output register.
// Depends on hrhp_pkg.
module hrhp_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  hrhp_pkg::qent_t q_data,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_echo_byte,
  output logic [2:0]      out_byte_role,
  output logic            out_header_begin,
  output logic [9:0]      out_status_code,
  output logic [1:0]      out_parse_result
);

  localparam logic [4:0] PH_H      = 5'd0;
  localparam logic [4:0] PH_T1     = 5'd1;
  localparam logic [4:0] PH_T2     = 5'd2;
  localparam logic [4:0] PH_P      = 5'd3;
  localparam logic [4:0] PH_SLASH  = 5'd4;
  localparam logic [4:0] PH_MAJ0   = 5'd5;
  localparam logic [4:0] PH_MAJ    = 5'd6;
  localparam logic [4:0] PH_MIN0   = 5'd7;
  localparam logic [4:0] PH_MIN    = 5'd8;
  localparam logic [4:0] PH_C1     = 5'd9;
  localparam logic [4:0] PH_C2     = 5'd10;
  localparam logic [4:0] PH_C3     = 5'd11;
  localparam logic [4:0] PH_REASON = 5'd12;
  localparam logic [4:0] PH_LINE   = 5'd13;
  localparam logic [4:0] PH_LWS    = 5'd14;
  localparam logic [4:0] PH_NAME   = 5'd15;
  localparam logic [4:0] PH_SPC    = 5'd16;
  localparam logic [4:0] PH_VALUE  = 5'd17;
  localparam logic [4:0] PH_LF2    = 5'd18;
  localparam logic [4:0] PH_LF3    = 5'd19;
  localparam logic [4:0] PH_BODY   = 5'd20;

  logic [4:0] phase_r, phase_nxt;
  logic [9:0] code_r, code_nxt;
  logic       seen_r, seen_nxt;
  logic       err_r, err_nxt;
  logic       out_valid_r;
  logic [7:0] echo_r;
  logic [2:0] role_r;
  logic       begin_r;
  logic [9:0] status_r;
  logic [1:0] res_r;

  logic [4:0] ph, nx;
  logic [9:0] code, code_upd;
  logic       seen, err, bad;
  logic [2:0] role;
  logic       hbeg;
  logic [1:0] res;
  logic [7:0] c;
  logic [9:0] dig;

  assign c   = q_data.data;
  assign dig = {6'd0, 4'(c - hrhp_pkg::CH_ZERO)};

  assign q_pop = q_valid && (!out_valid_r || out_ready);

  always_comb begin
    // A start flag resets the parser before the byte is consumed.
    ph   = q_data.start ? PH_H : phase_r;
    code = q_data.start ? 10'd0 : code_r;
    seen = q_data.start ? 1'b0 : seen_r;
    err  = q_data.start ? 1'b0 : err_r;
    nx   = ph;
    code_upd = code;
    bad  = 1'b0;
    role = hrhp_pkg::ROLE_FRAME;
    hbeg = 1'b0;
    res  = hrhp_pkg::RES_BUSY;
    if (err) begin
      bad = 1'b1;
    end else begin
      case (ph)
        PH_H:     if (c == hrhp_pkg::CH_H) nx = PH_T1; else bad = 1'b1;
        PH_T1:    if (c == hrhp_pkg::CH_T) nx = PH_T2; else bad = 1'b1;
        PH_T2:    if (c == hrhp_pkg::CH_T) nx = PH_P; else bad = 1'b1;
        PH_P:     if (c == hrhp_pkg::CH_P) nx = PH_SLASH; else bad = 1'b1;
        PH_SLASH: if (c == hrhp_pkg::CH_SLASH) nx = PH_MAJ0; else bad = 1'b1;
        PH_MAJ0: begin
          if (q_data.cls.digit) begin
            role = hrhp_pkg::ROLE_VER;
            nx = PH_MAJ;
          end else bad = 1'b1;
        end
        PH_MAJ: begin
          if (c == hrhp_pkg::CH_DOT) begin
            role = hrhp_pkg::ROLE_VER;
            nx = PH_MIN0;
          end else if (q_data.cls.digit) role = hrhp_pkg::ROLE_VER;
          else bad = 1'b1;
        end
        PH_MIN0: begin
          if (q_data.cls.digit) begin
            role = hrhp_pkg::ROLE_VER;
            nx = PH_MIN;
          end else bad = 1'b1;
        end
        PH_MIN: begin
          if (c == hrhp_pkg::CH_SP) nx = PH_C1;
          else if (q_data.cls.digit) role = hrhp_pkg::ROLE_VER;
          else bad = 1'b1;
        end
        PH_C1: begin
          if (q_data.cls.digit) begin
            code_upd = dig;
            nx = PH_C2;
          end else bad = 1'b1;
        end
        PH_C2, PH_C3: begin
          if (q_data.cls.digit) begin
            code_upd = (code << 3) + (code << 1) + dig;
            nx = (ph == PH_C2) ? PH_C3 : PH_REASON;
          end else bad = 1'b1;
        end
        PH_REASON: if (c == hrhp_pkg::CH_LF) nx = PH_LINE;
        PH_LINE: begin
          if (c == hrhp_pkg::CH_CR) nx = PH_LF3;
          else if (seen && q_data.cls.lws) nx = PH_LWS;
          else if (!q_data.cls.token) bad = 1'b1;
          else begin
            seen = 1'b1;
            role = hrhp_pkg::ROLE_NAME;
            hbeg = 1'b1;
            nx = PH_NAME;
          end
        end
        PH_LWS: begin
          if (c == hrhp_pkg::CH_CR) nx = PH_LF2;
          else if (q_data.cls.lws) nx = PH_LWS;
          else if (q_data.cls.ctl) bad = 1'b1;
          else begin
            role = hrhp_pkg::ROLE_VALUE;
            nx = PH_VALUE;
          end
        end
        PH_NAME: begin
          if (c == hrhp_pkg::CH_COLON) nx = PH_SPC;
          else if (!q_data.cls.token) bad = 1'b1;
          else role = hrhp_pkg::ROLE_NAME;
        end
        PH_SPC:   if (c == hrhp_pkg::CH_SP) nx = PH_VALUE; else bad = 1'b1;
        PH_VALUE: begin
          if (c == hrhp_pkg::CH_CR) nx = PH_LF2;
          else if (q_data.cls.ctl) bad = 1'b1;
          else role = hrhp_pkg::ROLE_VALUE;
        end
        PH_LF2:   if (c == hrhp_pkg::CH_LF) nx = PH_LINE; else bad = 1'b1;
        PH_LF3: begin
          if (c == hrhp_pkg::CH_LF) begin
            nx = PH_BODY;
            res = hrhp_pkg::RES_DONE;
          end else bad = 1'b1;
        end
        PH_BODY:  role = hrhp_pkg::ROLE_BODY;
        default:  bad = 1'b1;
      endcase
    end
    // A rejected byte leaves the phase and the code where they were.
    if (bad) begin
      role      = hrhp_pkg::ROLE_FRAME;
      hbeg      = 1'b0;
      res       = hrhp_pkg::RES_BAD;
      err_nxt   = 1'b1;
      phase_nxt = ph;
      code_nxt  = code;
      seen_nxt  = q_data.start ? 1'b0 : seen_r;
    end else begin
      err_nxt   = err;
      phase_nxt = nx;
      code_nxt  = code_upd;
      seen_nxt  = seen;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_H;
      code_r      <= '0;
      seen_r      <= 1'b0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        phase_r <= phase_nxt;
        code_r  <= code_nxt;
        seen_r  <= seen_nxt;
        err_r   <= err_nxt;
      end
      if (q_pop) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      echo_r   <= c;
      role_r   <= role;
      begin_r  <= hbeg;
      status_r <= code_nxt;
      res_r    <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_echo_byte    = echo_r;
  assign out_byte_role    = role_r;
  assign out_header_begin = begin_r;
  assign out_status_code  = status_r;
  assign out_parse_result = res_r;

endmodule

// ----- src/http_response_head_parser.sv -----
// Top level of the HTTP response head parser: classifier, queue, state machine.
// Depends on hrhp_pkg, hrhp_front, hrhp_fifo and hrhp_back.
//
//  channel | direction | payload                                         | handshake
//  in_     | input     | start_req, data_byte                            | in_valid / in_ready
//  out_    | output    | echo_byte, byte_role, header_begin,             | out_valid / out_ready
//          |           | status_code, parse_result                       |
//
// One byte per cycle sustained while out_ready stays high; a byte accepted at a clock
// edge is written into the queue at that edge and stepped into the output register
// when the back end pops it, which waits while the output register is stalled.
// With out_ready low, the output register and the four-entry queue take up to five
// bytes before in_ready falls; popping a full queue leaves in_ready low that cycle.
// Reset is synchronous and clears the queue, the parse state and out_valid;
// no clearing pass is needed, so a byte may be taken right after reset.
module http_response_head_parser (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_start_req,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_echo_byte,
  output logic [2:0] out_byte_role,
  output logic       out_header_begin,
  output logic [9:0] out_status_code,
  output logic [1:0] out_parse_result
);

  hrhp_pkg::qent_t wr_ent, rd_ent;
  logic            q_full, q_valid, q_pop;

  assign in_ready = !q_full;

  hrhp_front u_front (
    .in_start_req (in_start_req),
    .in_data_byte (in_data_byte),
    .ent          (wr_ent)
  );

  hrhp_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (in_valid && !q_full),
    .wr_data   (wr_ent),
    .full      (q_full),
    .rd_en     (q_pop),
    .not_empty (q_valid),
    .rd_data   (rd_ent)
  );

  hrhp_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_data           (rd_ent),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_echo_byte    (out_echo_byte),
    .out_byte_role    (out_byte_role),
    .out_header_begin (out_header_begin),
    .out_status_code  (out_status_code),
    .out_parse_result (out_parse_result)
  );

endmodule

// ----- src/hrhp_checker.sv -----
// Port-level checker for the HTTP response head parser, bound to the top level.
// Depends on hrhp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hrhp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_echo_byte,
  input logic [2:0] out_byte_role,
  input logic       out_header_begin,
  input logic [1:0] out_parse_result
);

  // A stalled result holds its byte.
  `ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_echo_byte))

  // A rejected byte carries no role and opens no header.
  `ASSERT_IMP(a_bad_quiet, clk, rst_n, out_valid && out_parse_result == hrhp_pkg::RES_BAD, out_byte_role == hrhp_pkg::ROLE_FRAME && !out_header_begin)

  // A new header always starts on a header name byte.
  `ASSERT_IMP(a_begin_name, clk, rst_n, out_valid && out_header_begin, out_byte_role == hrhp_pkg::ROLE_NAME)

  // The head completes only on the LF of the blank line.
  `ASSERT_IMP(a_done_lf, clk, rst_n, out_valid && out_parse_result == hrhp_pkg::RES_DONE, out_echo_byte == hrhp_pkg::CH_LF && out_byte_role == hrhp_pkg::ROLE_FRAME)

endmodule

bind http_response_head_parser hrhp_checker u_hrhp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_echo_byte    (out_echo_byte),
  .out_byte_role    (out_byte_role),
  .out_header_begin (out_header_begin),
  .out_parse_result (out_parse_result)
);

// ----- sim/http_response_head_parser_test.sv -----
// Self-checking testbench for http_response_head_parser: drives random HTTP heads
// and checks every tagged byte against a cycle-free predictor in a scoreboard class.
// Depends on hrhp_pkg and the http_response_head_parser RTL.
module http_response_head_parser_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [4:0] {
    P_EXP_H, P_EXP_T1, P_EXP_T2, P_EXP_P, P_EXP_SLASH,
    P_MAJOR_FIRST, P_MAJOR_MORE, P_MINOR_FIRST, P_MINOR_MORE,
    P_CODE_1, P_CODE_2, P_CODE_3, P_REASON,
    P_LINE_START, P_CONT_LWS, P_NAME, P_AFTER_COLON, P_VALUE,
    P_LF_HEADER, P_LF_END, P_BODY
  } head_phase_t;

  typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_BEAT} rx_mode_t;

  typedef struct {
    logic [7:0] echo;
    logic [2:0] role;
    logic       hdr_begin;
    logic [9:0] code;
    logic [1:0] result;
  } byte_tag_t;

  class head_tag_scoreboard;
    head_phase_t phase;
    logic [9:0]  code;
    logic        hdr_seen;
    logic        err;
    byte_tag_t   expected_tags[$];
    int          errors;
    int          checked;
    int          heads_done;
    int          bytes_bad;

    function new();
      clear_parse();
      errors = 0;
      checked = 0;
      heads_done = 0;
      bytes_bad = 0;
    endfunction

    function void clear_parse();
      phase = P_EXP_H;
      code = '0;
      hdr_seen = 1'b0;
      err = 1'b0;
    endfunction

    function bit is_num(logic [7:0] c);
      return c >= hrhp_pkg::CH_ZERO && c <= 8'h39;
    endfunction

    function bit is_ctl(logic [7:0] c);
      return c <= 8'd31 || c == 8'd127;
    endfunction

    function bit is_sep(logic [7:0] c);
      case (c)
        8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h3A, 8'h5C, 8'h22,
        8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B, 8'h7D,
        hrhp_pkg::CH_SP, hrhp_pkg::CH_TAB: return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    function bit is_token(logic [7:0] c);
      return c <= 8'd127 && !is_ctl(c) && !is_sep(c);
    endfunction

    function int pending();
      return expected_tags.size();
    endfunction

    // Advances the parse state by one accepted byte and queues its expected tag.
    function void note_byte(logic start, logic [7:0] c);
      byte_tag_t   t;
      head_phase_t nx;
      logic        bad;
      if (start) clear_parse();
      t.echo = c;
      t.role = hrhp_pkg::ROLE_FRAME;
      t.hdr_begin = 1'b0;
      t.result = hrhp_pkg::RES_BUSY;
      nx = phase;
      bad = 1'b0;
      if (err) begin
        bad = 1'b1;
      end else begin
        case (phase)
          P_EXP_H:     if (c == hrhp_pkg::CH_H) nx = P_EXP_T1; else bad = 1'b1;
          P_EXP_T1:    if (c == hrhp_pkg::CH_T) nx = P_EXP_T2; else bad = 1'b1;
          P_EXP_T2:    if (c == hrhp_pkg::CH_T) nx = P_EXP_P; else bad = 1'b1;
          P_EXP_P:     if (c == hrhp_pkg::CH_P) nx = P_EXP_SLASH; else bad = 1'b1;
          P_EXP_SLASH: if (c == hrhp_pkg::CH_SLASH) nx = P_MAJOR_FIRST; else bad = 1'b1;
          P_MAJOR_FIRST: begin
            if (is_num(c)) begin
              t.role = hrhp_pkg::ROLE_VER;
              nx = P_MAJOR_MORE;
            end else bad = 1'b1;
          end
          P_MAJOR_MORE: begin
            if (c == hrhp_pkg::CH_DOT) begin
              t.role = hrhp_pkg::ROLE_VER;
              nx = P_MINOR_FIRST;
            end else if (is_num(c)) t.role = hrhp_pkg::ROLE_VER;
            else bad = 1'b1;
          end
          P_MINOR_FIRST: begin
            if (is_num(c)) begin
              t.role = hrhp_pkg::ROLE_VER;
              nx = P_MINOR_MORE;
            end else bad = 1'b1;
          end
          P_MINOR_MORE: begin
            if (c == hrhp_pkg::CH_SP) nx = P_CODE_1;
            else if (is_num(c)) t.role = hrhp_pkg::ROLE_VER;
            else bad = 1'b1;
          end
          P_CODE_1: begin
            if (is_num(c)) begin
              code = 10'(c - hrhp_pkg::CH_ZERO);
              nx = P_CODE_2;
            end else bad = 1'b1;
          end
          P_CODE_2, P_CODE_3: begin
            if (is_num(c)) begin
              code = code * 10'd10 + 10'(c - hrhp_pkg::CH_ZERO);
              nx = (phase == P_CODE_2) ? P_CODE_3 : P_REASON;
            end else bad = 1'b1;
          end
          P_REASON: if (c == hrhp_pkg::CH_LF) nx = P_LINE_START;
          P_LINE_START: begin
            // A leading space or tab only continues a header once one exists.
            if (c == hrhp_pkg::CH_CR) nx = P_LF_END;
            else if (hdr_seen && (c == hrhp_pkg::CH_SP || c == hrhp_pkg::CH_TAB))
              nx = P_CONT_LWS;
            else if (!is_token(c)) bad = 1'b1;
            else begin
              hdr_seen = 1'b1;
              t.role = hrhp_pkg::ROLE_NAME;
              t.hdr_begin = 1'b1;
              nx = P_NAME;
            end
          end
          P_CONT_LWS: begin
            if (c == hrhp_pkg::CH_CR) nx = P_LF_HEADER;
            else if (c == hrhp_pkg::CH_SP || c == hrhp_pkg::CH_TAB) nx = P_CONT_LWS;
            else if (is_ctl(c)) bad = 1'b1;
            else begin
              t.role = hrhp_pkg::ROLE_VALUE;
              nx = P_VALUE;
            end
          end
          P_NAME: begin
            if (c == hrhp_pkg::CH_COLON) nx = P_AFTER_COLON;
            else if (!is_token(c)) bad = 1'b1;
            else t.role = hrhp_pkg::ROLE_NAME;
          end
          P_AFTER_COLON: if (c == hrhp_pkg::CH_SP) nx = P_VALUE; else bad = 1'b1;
          P_VALUE: begin
            if (c == hrhp_pkg::CH_CR) nx = P_LF_HEADER;
            else if (is_ctl(c)) bad = 1'b1;
            else t.role = hrhp_pkg::ROLE_VALUE;
          end
          P_LF_HEADER: if (c == hrhp_pkg::CH_LF) nx = P_LINE_START; else bad = 1'b1;
          P_LF_END: begin
            if (c == hrhp_pkg::CH_LF) begin
              nx = P_BODY;
              t.result = hrhp_pkg::RES_DONE;
            end else bad = 1'b1;
          end
          P_BODY: t.role = hrhp_pkg::ROLE_BODY;
          default: bad = 1'b1;
        endcase
      end
      if (bad) begin
        err = 1'b1;
        t.role = hrhp_pkg::ROLE_FRAME;
        t.hdr_begin = 1'b0;
        t.result = hrhp_pkg::RES_BAD;
      end else begin
        phase = nx;
      end
      t.code = code;
      expected_tags.insert(expected_tags.size(), t);
    endfunction

    function void check_tag(logic [7:0] echo, logic [2:0] role, logic hdr_begin,
                            logic [9:0] code_out, logic [1:0] result);
      byte_tag_t t;
      checked++;
      if (result == hrhp_pkg::RES_DONE) heads_done++;
      if (result == hrhp_pkg::RES_BAD) bytes_bad++;
      if (expected_tags.size() == 0) begin
        $error("result transaction with no byte outstanding: echo_byte %0d", echo);
        errors++;
        return;
      end
      t = expected_tags.pop_front();
      if (echo !== t.echo) begin
        $error("echo_byte: expected %0d, actual %0d", t.echo, echo);
        errors++;
      end
      if (role !== t.role) begin
        $error("byte_role: expected %0d, actual %0d", t.role, role);
        errors++;
      end
      if (hdr_begin !== t.hdr_begin) begin
        $error("header_begin: expected %0d, actual %0d", t.hdr_begin, hdr_begin);
        errors++;
      end
      if (code_out !== t.code) begin
        $error("status_code: expected %0d, actual %0d", t.code, code_out);
        errors++;
      end
      if (result !== t.result) begin
        $error("parse_result: expected %0d, actual %0d", t.result, result);
        errors++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       in_start_req = 1'b0;
  logic [7:0] in_data_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_echo_byte;
  logic [2:0] out_byte_role;
  logic       out_header_begin;
  logic [9:0] out_status_code;
  logic [1:0] out_parse_result;

  head_tag_scoreboard sb;
  logic [7:0] resp_bytes[$];
  int burst_left = 0;
  int sent_bytes = 0;
  int sent_resps = 0;

  http_response_head_parser dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_start_req     (in_start_req),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_echo_byte    (out_echo_byte),
    .out_byte_role    (out_byte_role),
    .out_header_begin (out_header_begin),
    .out_status_code  (out_status_code),
    .out_parse_result (out_parse_result)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("TEST FAILED");
    $finish;
  end

  // Both channels are sampled at the edge, before any new drive lands.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_byte(in_start_req, in_data_byte);
      if (out_valid && out_ready)
        sb.check_tag(out_echo_byte, out_byte_role, out_header_begin,
                     out_status_code, out_parse_result);
    end
  end

  // Receiver back-pressure: switches between several stall patterns.
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_left = 0;
  int       rx_cycle = 0;
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(32, 200);
    end else begin
      rx_left--;
    end
    rx_cycle++;
    case (rx_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
      default:   out_ready <= (rx_cycle % 4 != 3);
    endcase
  end

  task automatic send_byte(input logic start, input logic [7:0] data);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      burst_left = ($urandom_range(0, 4) == 0) ? 100 : $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_start_req <= start;
    in_data_byte <= data;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    sent_bytes++;
  endtask

  task automatic send_resp();
    for (int i = 0; i < resp_bytes.size(); i++) send_byte(i == 0, resp_bytes[i]);
    resp_bytes.delete();
    sent_resps++;
  endtask

  task automatic append_byte(input logic [7:0] b);
    resp_bytes.insert(resp_bytes.size(), b);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) append_byte(s[i]);
  endtask

  task automatic push_digits(input int lo, input int hi);
    int n;
    n = $urandom_range(lo, hi);
    repeat (n) append_byte(hrhp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  task automatic push_value(input int hi);
    logic [7:0] c;
    int n;
    n = $urandom_range(0, hi);
    repeat (n) begin
      do c = 8'($urandom_range(0, 255)); while (sb.is_ctl(c));
      append_byte(c);
    end
  endtask

  task automatic push_line_end();
    append_byte(hrhp_pkg::CH_CR);
    append_byte(hrhp_pkg::CH_LF);
  endtask

  // A complete, valid head with random content, followed by a short body.
  task automatic build_well_formed();
    logic [7:0] c;
    int n;
    push_text("HTTP/");
    push_digits(1, 2);
    append_byte(hrhp_pkg::CH_DOT);
    push_digits(1, 2);
    append_byte(hrhp_pkg::CH_SP);
    push_digits(3, 3);
    if ($urandom_range(0, 9) < 7) append_byte(hrhp_pkg::CH_SP);
    n = $urandom_range(0, 5);
    repeat (n) begin
      do c = 8'($urandom_range(0, 255)); while (c == hrhp_pkg::CH_LF);
      append_byte(c);
    end
    append_byte(hrhp_pkg::CH_LF);
    repeat ($urandom_range(0, 3)) begin
      n = $urandom_range(1, 5);
      repeat (n) begin
        do c = 8'($urandom_range(33, 126)); while (!sb.is_token(c));
        append_byte(c);
      end
      append_byte(hrhp_pkg::CH_COLON);
      append_byte(hrhp_pkg::CH_SP);
      push_value(5);
      push_line_end();
      if ($urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 3);
        repeat (n) append_byte($urandom_range(0, 1) ? hrhp_pkg::CH_SP : hrhp_pkg::CH_TAB);
        push_value(4);
        push_line_end();
      end
    end
    push_line_end();
    n = $urandom_range(0, 6);
    repeat (n) append_byte(8'($urandom_range(0, 255)));
  endtask

  initial begin
    int kind;
    int pos;
    int keep;
    int n;
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Shortest head with no headers, highest status code, extreme body bytes.
    push_text("HTTP/0.9 999");
    append_byte(hrhp_pkg::CH_LF);
    push_line_end();
    append_byte(8'hFF);
    append_byte(8'h00);
    send_resp();
    // Continuation line before any header is rejected, and the error then sticks.
    push_text("HTTP/1.1 200");
    append_byte(hrhp_pkg::CH_LF);
    append_byte(hrhp_pkg::CH_SP);
    append_byte(8'hFF);
    send_resp();

    while (sent_bytes < 600) begin
      kind = $urandom_range(0, 99);
      build_well_formed();
      if (kind < 15) begin
        resp_bytes.delete();
        n = $urandom_range(1, 8);
        repeat (n) append_byte(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1)) resp_bytes[0] = hrhp_pkg::CH_H;
      end else if (kind < 35) begin
        pos = $urandom_range(0, resp_bytes.size() - 1);
        resp_bytes[pos] = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 1)) begin
          keep = $urandom_range(pos + 1, resp_bytes.size());
          while (resp_bytes.size() > keep) resp_bytes.delete(resp_bytes.size() - 1);
        end
      end
      send_resp();
    end
    in_valid <= 1'b0;

    while (sb.checked < sent_bytes) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d bytes in %0d responses; %0d tags checked.",
             sent_bytes, sent_resps, sb.checked);
    $display("Heads completed: %0d, rejected bytes: %0d.", sb.heads_done, sb.bytes_bad);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+src
src/hrhp_pkg.sv
src/hrhp_front.sv
src/hrhp_fifo.sv
src/hrhp_back.sv
src/http_response_head_parser.sv
src/hrhp_checker.sv
sim/http_response_head_parser_test.sv
